FILE: rtl/frame_rate_moving_average_assert.svh
// ----------------------------------------------------------------------------
// frame rate moving average assertion macros
// concurrent check macros included by frame_rate_moving_average.sv
// ----------------------------------------------------------------------------
`ifndef FRAME_RATE_MOVING_AVERAGE_ASSERT_SVH
`define FRAME_RATE_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication
`define FRMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/frma_pkg.sv
// ----------------------------------------------------------------------------
// frame rate moving average package
// window size, field widths and sequencer states
// ----------------------------------------------------------------------------
package frma_pkg;

    localparam int WINDOW   = 50;
    localparam int TIME_W   = 32;
    localparam int RATE_W   = 20;
    localparam int TOTAL_W  = RATE_W + $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int STEP_W   = $clog2(TOTAL_W);

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = RATE_W'(1000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_RATE,
        S_UPDATE,
        S_DIV_AVG,
        S_DONE
    } frma_state_t;

endpackage

FILE: rtl/frma_ram.sv
// ----------------------------------------------------------------------------
// frma generic ram
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module frma_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 50
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/frame_rate_moving_average.sv
// ----------------------------------------------------------------------------
// frame rate moving average
// averages tick_rate_hz / frame interval over the last WINDOW frames
// ----------------------------------------------------------------------------
// Each accepted frame_time word yields one frame_rate word, and in_ready is
// low until the sequencer returns to S_IDLE. The figure comes from one shared
// restoring divider that produces one quotient bit per cycle and runs twice
// per word: first for the instantaneous rate, then for the window average,
// with the S_UPDATE window update between the runs and S_DONE loading the
// output register once it is free. The rate history sits in a WINDOW-entry
// RAM; entries are only used once the window has filled, so no clearing pass
// follows reset. A finished word waits in the output register and the next
// frame_time word may be accepted meanwhile.
module frame_rate_moving_average (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [frma_pkg::RATE_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [frma_pkg::TIME_W-1:0] frame_time,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [frma_pkg::RATE_W-1:0] frame_rate
);

    import frma_pkg::*;

`include "frame_rate_moving_average_assert.svh"

    frma_state_t         state_reg, state_next;

    logic [RATE_W-1:0]   tick_rate_reg;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic                diff_zero_reg, diff_zero_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [TOTAL_W-1:0]  div_dvd_reg, div_dvd_next;
    logic [TIME_W-1:0]   div_dsr_reg, div_dsr_next;
    logic [TIME_W-1:0]   div_rem_reg, div_rem_next;

    logic                out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]   out_rate_reg, out_rate_next;

    logic [TIME_W:0]     rem_shift;
    logic [TIME_W:0]     dsr_ext;
    logic                fits;
    logic [TIME_W:0]     rem_sub;
    logic [TIME_W-1:0]   rem_step;
    logic [TOTAL_W-1:0]  dvd_step;
    logic                last_step;

    logic                full;
    logic [RATE_W-1:0]   rate;
    logic [TOTAL_W-1:0]  total_upd;
    logic [FILL_W-1:0]   fill_upd;

    logic                ram_we;
    logic                ram_re;
    logic [RATE_W-1:0]   ram_rdata;
    logic                in_accept;

    frma_ram #(
        .WIDTH (RATE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (rate),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // shared divider step, one quotient bit per cycle
    assign rem_shift = {div_rem_reg, div_dvd_reg[TOTAL_W-1]};
    assign dsr_ext   = {1'b0, div_dsr_reg};
    assign fits      = (rem_shift >= dsr_ext);
    assign rem_sub   = rem_shift - dsr_ext;
    assign rem_step  = fits ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
    assign dvd_step  = {div_dvd_reg[TOTAL_W-2:0], fits};
    assign last_step = (step_reg == STEP_W'(TOTAL_W - 1));

    // window update
    assign full      = (fill_reg == FILL_W'(WINDOW));
    assign rate      = diff_zero_reg ? '0 : div_dvd_reg[RATE_W-1:0];
    assign total_upd = total_reg - (full ? TOTAL_W'(ram_rdata) : '0) + TOTAL_W'(rate);
    assign fill_upd  = full ? fill_reg : fill_reg + FILL_W'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign ram_re    = in_accept;
    assign ram_we    = (state_reg == S_UPDATE);

    assign out_valid  = out_valid_reg;
    assign frame_rate = out_rate_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_rate_reg <= TICK_RATE_RESET;
            last_time_reg <= '0;
            total_reg     <= '0;
            fill_reg      <= '0;
            slot_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            total_reg     <= total_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                tick_rate_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        diff_zero_reg <= diff_zero_next;
        div_dvd_reg   <= div_dvd_next;
        div_dsr_reg   <= div_dsr_next;
        div_rem_reg   <= div_rem_next;
        out_rate_reg  <= out_rate_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        last_time_next = last_time_reg;
        diff_zero_next = diff_zero_reg;
        total_next     = total_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        step_next      = step_reg;
        div_dvd_next   = div_dvd_reg;
        div_dsr_next   = div_dsr_reg;
        div_rem_next   = div_rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_rate_next  = out_rate_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_time_next = frame_time;
                    div_dsr_next   = frame_time - last_time_reg;
                    diff_zero_next = (frame_time == last_time_reg);
                    div_dvd_next   = TOTAL_W'(tick_rate_reg);
                    div_rem_next   = '0;
                    step_next      = '0;
                    state_next     = S_DIV_RATE;
                end
            end
            S_DIV_RATE, S_DIV_AVG:
            begin
                div_dvd_next = dvd_step;
                div_rem_next = rem_step;
                step_next    = step_reg + STEP_W'(1);
                if (last_step)
                begin
                    state_next = (state_reg == S_DIV_RATE) ? S_UPDATE : S_DONE;
                end
            end
            S_UPDATE:
            begin
                total_next   = total_upd;
                fill_next    = fill_upd;
                slot_next    = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + SLOT_W'(1);
                div_dvd_next = total_upd;
                div_dsr_next = TIME_W'(fill_upd);
                div_rem_next = '0;
                step_next    = '0;
                state_next   = S_DIV_AVG;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = div_dvd_reg[RATE_W-1:0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `FRMA_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FILL_W'(WINDOW), "fill count above window")
    `FRMA_ASSERT_NOW(a_slot_bound, clk, rst_n, 1'b1, slot_reg < SLOT_W'(WINDOW), "write slot out of range")
    `FRMA_ASSERT_NEXT(a_start_div, clk, rst_n, in_accept, state_reg == S_DIV_RATE, "accepted word did not start the rate division")
    `FRMA_ASSERT_NEXT(a_done_out, clk, rst_n, state_reg == S_DONE && (!out_valid_reg || out_ready), out_valid_reg && state_reg == S_IDLE, "finished average not presented")

endmodule

FILE: tb/frame_rate_moving_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame rate moving average checker
// watches the tick rate register and both word channels, keeps its own
// window of instantaneous rates and compares every frame_rate word in order
// ----------------------------------------------------------------------------
module frame_rate_moving_average_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [frma_pkg::RATE_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [frma_pkg::TIME_W-1:0] frame_time,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [frma_pkg::RATE_W-1:0] frame_rate,
    output int                          mismatch_count,
    output int                          words_pending,
    output int                          words_checked
);

    import frma_pkg::*;

    logic [RATE_W-1:0]  tick_rate;
    logic [RATE_W-1:0]  rate_hist [WINDOW];
    logic [TOTAL_W-1:0] rate_sum;
    logic [SLOT_W-1:0]  next_slot;
    logic [FILL_W-1:0]  filled;
    logic [TIME_W-1:0]  prev_stamp;
    logic [RATE_W-1:0]  pending_averages [$];
    logic [RATE_W-1:0]  wanted;
    int                 fails;
    int                 checked;

    function automatic logic [RATE_W-1:0] average_after_frame(input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] delta;
        logic [RATE_W-1:0] rate;
        delta = stamp - prev_stamp;
        rate  = (delta == '0) ? '0 : RATE_W'(TIME_W'(tick_rate) / delta);
        prev_stamp = stamp;
        // full window: drop the oldest rate before it is overwritten
        if (filled == FILL_W'(WINDOW))
        begin
            rate_sum = rate_sum - TOTAL_W'(rate_hist[next_slot]);
        end
        else
        begin
            filled = filled + FILL_W'(1);
        end
        rate_hist[next_slot] = rate;
        rate_sum  = rate_sum + TOTAL_W'(rate);
        next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + SLOT_W'(1);
        return RATE_W'(rate_sum / TOTAL_W'(filled));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate  = TICK_RATE_RESET;
            rate_sum   = '0;
            next_slot  = '0;
            filled     = '0;
            prev_stamp = '0;
            fails      = 0;
            checked    = 0;
            pending_averages.delete();
            mismatch_count <= 0;
            words_pending  <= 0;
            words_checked  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_averages.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("unexpected frame_rate word %0d", frame_rate);
                    end
                end
                else
                begin
                    wanted = pending_averages.pop_front();
                    checked++;
                    if (frame_rate !== wanted)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("frame_rate mismatch at word %0d: expected %0d, got %0d",
                                     checked, wanted, frame_rate);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                pending_averages.push_back(average_after_frame(frame_time));
            end
            if (cfg_we)
            begin
                tick_rate = cfg_wdata;
            end
            mismatch_count <= fails;
            words_pending  <= pending_averages.size();
            words_checked  <= checked;
        end
    end

endmodule

FILE: tb/frame_rate_moving_average_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame rate moving average testbench
// drives frame timestamps and tick rate settings into the block with random
// gaps on both channels; the checker predicts and compares the averages
// ----------------------------------------------------------------------------
module frame_rate_moving_average_tb;

    import frma_pkg::*;

    localparam int ITEMS_PER_PHASE = 180;
    localparam int PHASES          = 8;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [RATE_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic [TIME_W-1:0] frame_time;
    logic              out_valid;
    logic              out_ready;
    logic [RATE_W-1:0] frame_rate;

    int                mismatch_count;
    int                words_pending;
    int                words_checked;
    int                frames_sent;
    int                settings_used;
    int                rx_gap;
    bit                no_idle;
    logic [TIME_W-1:0] last_sent;
    logic [RATE_W-1:0] phase_rates [PHASES];

    frame_rate_moving_average i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .frame_time (frame_time),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_rate (frame_rate)
    );

    frame_rate_moving_average_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .frame_time     (frame_time),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_rate     (frame_rate),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .words_checked  (words_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 50)
        begin
            return 0;
        end
        if (pick < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 97)
        begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(40, 150);
    endfunction

    // mostly forward frame intervals over a wide range, plus repeats and jumps
    function automatic logic [TIME_W-1:0] next_stamp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            return last_sent + $urandom_range(1, 2 ** $urandom_range(0, 22));
        end
        if (pick < 80)
        begin
            return last_sent;
        end
        if (pick < 90)
        begin
            return $urandom();
        end
        return last_sent - $urandom_range(1, 1000);
    endfunction

    task automatic send_frame(input logic [TIME_W-1:0] stamp);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        frame_time <= stamp;
        do @(posedge clk); while (!in_ready);
        last_sent = stamp;
        frames_sent++;
    endtask

    task automatic set_tick_rate(input logic [RATE_W-1:0] value);
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            rx_gap = pick_gap();
            if (rx_gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_gap) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        frame_time    = '0;
        no_idle       = 1'b0;
        last_sent     = '0;
        frames_sent   = 0;
        settings_used = 1;
        phase_rates   = '{RATE_W'(1000000), RATE_W'($urandom_range(0, 20'hFFFFF)),
                          RATE_W'(60), 20'hFFFFF, RATE_W'(1), RATE_W'(0),
                          RATE_W'($urandom_range(0, 20'hFFFFF)), RATE_W'(1000)};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tick rate: first word, zero interval, wrap of the counter
        send_frame(32'h0000_0000);
        send_frame(32'h0000_0001);
        send_frame(32'h0000_0003);
        send_frame(32'h0000_0003);
        send_frame(32'd1003);
        send_frame(32'd2004);
        send_frame(32'hFFFF_FFFF);
        send_frame(32'h0000_0004);
        send_frame(32'h8000_0000);
        send_frame(32'h7FFF_FFFF);
        send_frame(32'hAAAA_AAAA);
        send_frame(32'h5555_5555);

        set_tick_rate(20'hFFFFF);
        send_frame(last_sent + 1);
        send_frame(last_sent + 1);
        send_frame(last_sent + 1);
        send_frame(last_sent + 2);

        set_tick_rate(20'h00000);
        send_frame(last_sent + 1);
        send_frame(last_sent + 1);

        set_tick_rate(RATE_W'(1));
        send_frame(last_sent + 1);
        send_frame(last_sent + 2);

        for (int p = 0; p < PHASES; p++)
        begin
            set_tick_rate(phase_rates[p]);
            no_idle = (p == 2 || p == 5);
            repeat (ITEMS_PER_PHASE) send_frame(next_stamp());
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (80) @(posedge clk);

        $display("%0d frame times sent under %0d tick rate settings, zero to full scale",
                 frames_sent, settings_used);
        $display("%0d averages checked, %0d-entry window filled and wrapped repeatedly",
                 words_checked, WINDOW);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/frma_pkg.sv
rtl/frma_ram.sv
rtl/frame_rate_moving_average.sv
tb/frame_rate_moving_average_checker.sv
tb/frame_rate_moving_average_tb.sv
